// ===== rtl/sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [4:0]         position;
    logic               overflow;
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         count;
  } out_item_t;
endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: one beat in, one result beat out per operation.
// A beat passes the input queue, then the cell array, which registers the result.
// One op per cycle unless the output stalls; every cell compares and shifts at once.
// Reset (rst, synchronous, active high) empties the queue and both handshake stages.
// Stored entries are not cleared; only entries below the count are ever used.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_stall,
  output spq_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_stall
);
  import spq_pkg::*;

  // The front queue takes beats while the cell array waits on the output.
  in_item_t q_item;
  logic     q_valid;
  logic     q_take;

  spq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_take   (q_take)
  );

  // The back end holds the sorted entries and registers every result.
  spq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .out_item  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );
endmodule

// ===== rtl/spq_front.sv =====
module spq_front (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_stall,
  output spq_pkg::in_item_t q_item,
  output logic              q_valid,
  input  logic              q_take
);
  import spq_pkg::*;

  // Two-entry queue between the input port and the list engine.
  in_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "sorted_priority_queue_assert.svh"
  `SPQ_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= 2'd2)
  `SPQ_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, fill == $past(fill) + 2'd1)
  `SPQ_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, fill == $past(fill) - 2'd1)
endmodule

// ===== rtl/spq_back.sv =====
module spq_back #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::in_item_t  q_item,
  input  logic               q_valid,
  output logic               q_take,
  output spq_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_stall
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Each cell compares its own entry against the key; all cells shift together.
  logic signed [31:0] entries [CAPACITY];
  logic [CW-1:0]      stored_count;
  logic [CW-1:0]      count_next;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] first_eq;
  logic [CAPACITY-1:0] past_eq;
  logic [CW-1:0]      hit_pos;
  logic               hit;
  logic               full;
  logic               do_ins;
  logic               do_rem;
  logic               fire;
  logic signed [31:0] head_next;
  op_t                op;

  assign op     = op_t'(q_item.operation);
  assign q_take = !out_valid || !out_stall;
  assign fire   = q_valid && q_take;
  assign full   = (stored_count == CW'(CAPACITY));

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CW'(i) < stored_count);
      ge[i]  = occ[i] && (entries[i] >= q_item.value);
      eq[i]  = occ[i] && (entries[i] == q_item.value);
    end
    past_eq[0]  = 1'b0;
    first_eq[0] = eq[0];
    for (int i = 1; i < CAPACITY; i++) begin
      past_eq[i]  = past_eq[i-1] || eq[i-1];
      first_eq[i] = eq[i] && !past_eq[i];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_eq[i]) begin
        hit_pos = CW'(i);
      end
    end
    hit    = |eq;
    do_ins = fire && (op == OP_INSERT) && !full;
    do_rem = fire && (op == OP_REMOVE) && hit;
    count_next = stored_count;
    if (do_ins) begin
      count_next = stored_count + CW'(1);
    end else if (do_rem) begin
      count_next = stored_count - CW'(1);
    end
    // Head after the operation.
    head_next = entries[0];
    if (do_ins && !ge[0]) begin
      head_next = q_item.value;
    end else if (do_rem && first_eq[0]) begin
      head_next = entries[1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_ins && !ge[i]) begin
        if (i == 0) begin
          entries[i] <= q_item.value;
        end else if (ge[i-1]) begin
          entries[i] <= q_item.value;
        end else begin
          entries[i] <= entries[i-1];
        end
      end else if (do_rem && (first_eq[i] || past_eq[i]) && i < CAPACITY - 1) begin
        entries[i] <= entries[i+1];
      end
    end
    if (fire) begin
      out_item.found      <= (op == OP_REMOVE || op == OP_FIND) && hit;
      out_item.position   <= ((op == OP_REMOVE || op == OP_FIND) && hit) ?
                             5'(hit_pos) : 5'd0;
      out_item.overflow   <= (op == OP_INSERT) && full;
      out_item.head_valid <= (count_next != '0);
      out_item.head_value <= (count_next != '0) ? head_next : 32'sd0;
      out_item.count      <= 5'(count_next);
    end
    if (rst) begin
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      stored_count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "sorted_priority_queue_assert.svh"
  `SPQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, stored_count <= CW'(CAPACITY))
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  `SPQ_ASSERT_IMP(a_ins_when_full, clk, rst, do_ins, !full)
endmodule

// ===== tb/spq_checker.sv =====
module spq_checker (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::in_item_t  in_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  spq_pkg::out_item_t out_data,
  input  logic               out_valid,
  input  logic               out_stall,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int CAPACITY = 16;

  logic signed [31:0] model_entries [CAPACITY];
  int                 model_count;
  out_item_t          expected_results [$];

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic out_item_t apply_op(input in_item_t item);
    out_item_t r;
    int        slot;
    int        hit;
    r = '0;
    hit = -1;
    if (op_t'(item.operation) == OP_REMOVE || op_t'(item.operation) == OP_FIND) begin
      for (int i = model_count - 1; i >= 0; i--)
        if (model_entries[i] == item.value) hit = i;
    end
    case (op_t'(item.operation))
      OP_INSERT: begin
        if (model_count >= CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          slot = 0;
          while (slot < model_count && model_entries[slot] >= item.value) slot++;
          for (int i = model_count; i > slot; i--) model_entries[i] = model_entries[i-1];
          model_entries[slot] = item.value;
          model_count++;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.position = hit[4:0];
          for (int i = hit; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.position = hit[4:0];
        end
      end
      default: ;
    endcase
    r.head_valid = model_count > 0;
    r.head_value = model_count > 0 ? model_entries[0] : '0;
    r.count = model_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      model_count <= 0;
      errors <= 0;
      expected_results.delete();
    end else begin
      // Sample both channels at the edge; predictions are made in input order.
      if (in_valid && !in_stall) expected_results.push_back(apply_op(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected beat", 64'(out_data), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found)
            report("found", 64'(out_data.found), 64'(want.found));
          if (out_data.position !== want.position)
            report("position", 64'(out_data.position), 64'(want.position));
          if (out_data.overflow !== want.overflow)
            report("overflow", 64'(out_data.overflow), 64'(want.overflow));
          if (out_data.head_value !== want.head_value)
            report("head_value", 64'(unsigned'(out_data.head_value)),
                   64'(unsigned'(want.head_value)));
          if (out_data.head_valid !== want.head_valid)
            report("head_valid", 64'(out_data.head_valid), 64'(want.head_valid));
          if (out_data.count !== want.count)
            report("count", 64'(out_data.count), 64'(want.count));
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_item_t  in_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  out_item_t out_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  int        errors;
  int        pending;

  // The receiver idles at random unless a quiet stretch or a long hold-off is active.
  bit        calm = 1'b0;
  bit        hold_off = 1'b0;

  // A small pool of keys makes duplicates, hits on remove and find, and full
  // queues common; the extremes of the signed range are in the pool too.
  logic signed [31:0] key_pool [8];

  always #10 clk = ~clk;

  sorted_priority_queue u_dut (
    .clk, .rst, .in_data, .in_valid, .in_stall, .out_data, .out_valid, .out_stall
  );

  spq_checker u_checker (
    .clk, .rst, .in_data, .in_valid, .in_stall, .out_data, .out_valid, .out_stall,
    .errors, .pending
  );

  // Receiver side: a new stall value is chosen at every edge.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || (!calm && $urandom_range(99) < 26);
  end

  // Offer one beat and keep it steady until the block takes it. Random gaps
  // come before the beat so that valid never depends on stall. Valid drops
  // only when a gap is taken, so back-to-back beats keep it high.
  task automatic send_beat(input op_t op, input logic signed [31:0] value);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= '{operation: op, value: value};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: pick_value = $urandom;
      default: pick_value = key_pool[$urandom_range(7)];
    endcase
  endfunction

  function automatic op_t pick_op(input int insert_weight);
    int roll;
    roll = $urandom_range(99);
    if (roll < insert_weight) pick_op = OP_INSERT;
    else if (roll < 70) pick_op = OP_REMOVE;
    else if (roll < 97) pick_op = OP_FIND;
    else pick_op = OP_NONE;
  endfunction

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: remove and find on an empty queue, the unused code, both extremes,
    // duplicates, then overfill past capacity and remove from the tail.
    send_beat(OP_REMOVE, 5);
    send_beat(OP_FIND, 5);
    send_beat(OP_NONE, 32'sh7fff_ffff);
    send_beat(OP_INSERT, 32'sh8000_0000);
    send_beat(OP_INSERT, 32'sh7fff_ffff);
    send_beat(OP_INSERT, 0);
    send_beat(OP_INSERT, 0);
    send_beat(OP_FIND, 0);
    send_beat(OP_FIND, 32'sh8000_0000);
    send_beat(OP_REMOVE, 0);
    send_beat(OP_REMOVE, 32'sh7fff_ffff);
    send_beat(OP_NONE, -1);
    for (int i = 0; i < 14; i++) send_beat(OP_INSERT, -i);
    send_beat(OP_INSERT, 32'sh5555_aaaa);
    send_beat(OP_FIND, -13);
    send_beat(OP_REMOVE, 32'sh8000_0000);

    // Long hold-off: the receiver stalls while the sender keeps offering,
    // so the block fills up and stalls its input.
    calm = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_beat(OP_FIND, key_pool[i % 8]);
    join

    // Random part. Phases vary the insert share so the queue swings between
    // empty and full; one stretch runs with no idling at all.
    for (int n = 0; n < 820; n++) begin
      calm = (n >= 300 && n < 420);
      send_beat(pick_op((n / 100) % 2 ? 55 : 25), pick_value());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
